### sv/kat_pkg.sv
// Package: types, constants and helpers for the keyframe animation timeline.
package kat_pkg;

  localparam int MaxKeys   = 16;
  localparam int NumChan   = 4;
  localparam int KeyIdxW   = $clog2(MaxKeys);
  localparam int KeyCntW   = $clog2(MaxKeys + 1);
  localparam int AddrW     = $clog2(NumChan * MaxKeys);
  localparam int MemDepth  = NumChan * MaxKeys;
  localparam int EntryW    = 80;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_APPEND = 3'd1;
  localparam logic [2:0] FUNC_PAUSE  = 3'd2;
  localparam logic [2:0] FUNC_PLAY   = 3'd3;
  localparam logic [2:0] FUNC_INIT   = 3'd4;

  localparam logic [1:0] REG_DURATION    = 2'd0;
  localparam logic [1:0] REG_START_DELAY = 2'd1;
  localparam logic [1:0] REG_LOOP_ENABLE = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic [15:0]        delta_time;
    logic [1:0]         key_channel;
    logic [15:0]        key_ratio;
    logic signed [15:0] key_comp_a;
    logic signed [15:0] key_comp_b;
    logic signed [15:0] key_comp_c;
    logic signed [15:0] key_comp_d;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_channel;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic signed [15:0] value_c;
    logic signed [15:0] value_d;
    logic               is_paused;
    logic               last;
  } out_item_t;

  // Default value of an empty track, packed d,c,b,a from the top.
  function automatic logic [63:0] dflt_val(input logic [1:0] ch);
    logic [63:0] v;
    unique case (ch)
      2'd0:    v = {16'sd0,   16'sd0,   16'sd0,   16'sd0};
      2'd1:    v = {16'sd256, 16'sd0,   16'sd0,   16'sd0};
      2'd2:    v = {16'sd0,   16'sd256, 16'sd256, 16'sd256};
      default: v = {16'sd256, 16'sd256, 16'sd256, 16'sd256};
    endcase
    return v;
  endfunction

endpackage

### sv/keyframe_animation_timeline_top.sv
// Top level: keyframe animation timeline with four linearly interpolated tracks.
// Append, pause, play and initialize give no result. A tick runs the ratio division,
// then per track the key reads, weight division, multiply and round.
// A looping tick that passes the duration more than once finishes each extra wrap
//   before the ratio division starts; output stalls also hold the sequencer.
// One item at a time; the serial divider sets most time.
// Synchronous reset clears timeline state, key counts and loads register defaults; no memory clear.
module keyframe_animation_timeline_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kat_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kat_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import kat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RDIV, S_RWAIT, S_FIRST, S_LASTRD, S_LASTCHK, S_SCAN, S_SCANCHK,
    S_WDIV, S_WWAIT, S_MUL, S_ROUND, S_OUT
  } state_t;

  state_t state;

  logic [15:0] duration, start_delay;
  logic        loop_enable;
  logic [16:0] progress;
  logic [17:0] delay_left;
  logic        paused;
  logic        wrapping;
  logic [KeyCntW-1:0] key_count [NumChan];

  logic [15:0] ratio;
  logic [1:0]  ch;
  logic [KeyIdxW-1:0] idx;
  logic [15:0] r_lo;
  logic [63:0] v_lo, v_hi;
  logic [15:0] r_hi;
  logic [16:0] t;
  logic signed [33:0] prod [4];
  logic [63:0] res;

  // Key memory: ratio in the top 16 bits, components below
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [EntryW-1:0] mem_wdata, mem_rdata;
  logic [15:0]       rd_ratio;
  logic [63:0]       rd_val;

  assign rd_ratio = mem_rdata[79:64];
  assign rd_val   = mem_rdata[63:0];

  kat_ram #(.Width(EntryW), .Depth(MemDepth)) u_keys (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic        div_start, div_done;
  logic [32:0] div_n, div_q;
  logic [16:0] div_d;

  kat_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(div_q)
  );

  logic [16:0] dur;
  assign dur = (duration == 16'd0) ? 17'd1 : {1'b0, duration};

  logic [KeyCntW-1:0] n_cur;
  assign n_cur = key_count[ch];

  // Timeline advance for a tick
  logic [16:0] prog_sum, prog_next;
  logic [17:0] delay_next;
  logic        paused_next;
  logic        wrap_go;
  logic [16:0] wrap1;
  always_comb begin
    prog_next   = progress;
    delay_next  = delay_left;
    paused_next = paused;
    wrap_go     = 1'b0;
    prog_sum    = progress + {1'b0, in_data.delta_time};
    wrap1       = prog_sum - dur;
    if (!paused) begin
      if (delay_left != 18'd0) begin
        delay_next = (delay_left > {2'b0, in_data.delta_time}) ?
                     delay_left - {2'b0, in_data.delta_time} : 18'd0;
      end else if (prog_sum > dur) begin
        if (loop_enable) begin
          // One wrap here; a small duration can need more, finished one a cycle
          prog_next = wrap1;
          wrap_go   = 1'b1;
        end else begin
          prog_next   = dur;
          paused_next = 1'b1;
        end
      end else begin
        prog_next = prog_sum;
      end
    end
  end

  logic wrap_more;
  assign wrap_more = wrapping && (progress > dur);
  assign in_ready  = (state == S_IDLE) && !wrap_more;

  // Lerp rounding of the four products
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [33:0] s;
      s = prod[k] + 34'sd32768;
      res[16*k +: 16] = v_lo[16*k +: 16] + s[31:16];
    end
  end

  logic [63:0] chan_val;
  logic [AddrW-1:0] base;
  assign base = AddrW'({ch, {KeyIdxW{1'b0}}});

  // Sequencer
  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      duration    <= 16'd1000;
      start_delay <= 16'd0;
      loop_enable <= 1'b1;
      progress    <= '0;
      delay_left  <= '0;
      paused      <= 1'b0;
      wrapping    <= 1'b0;
      out_valid   <= 1'b0;
      for (int c = 0; c < NumChan; c++) key_count[c] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DURATION:    duration    <= cfg_wdata;
          REG_START_DELAY: start_delay <= cfg_wdata;
          REG_LOOP_ENABLE: loop_enable <= cfg_wdata[0];
          default: ;
        endcase
      end
      // Finish a multi-wrap one subtraction a cycle
      if (wrap_more) progress <= progress - dur;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            unique case (in_data.func)
              FUNC_APPEND: begin
                if (key_count[in_data.key_channel] < KeyCntW'(MaxKeys))
                  key_count[in_data.key_channel] <= key_count[in_data.key_channel] + 1'b1;
              end
              FUNC_PAUSE: paused <= 1'b1;
              FUNC_PLAY:  paused <= 1'b0;
              FUNC_INIT: begin
                progress   <= '0;
                delay_left <= {2'b0, start_delay};
              end
              FUNC_TICK: begin
                progress   <= prog_next;
                delay_left <= delay_next;
                paused     <= paused_next;
                wrapping   <= wrap_go;
                state      <= S_RDIV;
              end
              default: ;
            endcase
          end
        end
        S_RDIV: if (!wrap_more) begin
          wrapping  <= 1'b0;
          div_start <= 1'b1;
          state     <= S_RWAIT;
        end
        S_RWAIT: if (div_done) begin
          ratio <= (div_q > 33'd65535) ? 16'hFFFF : div_q[15:0];
          ch    <= 2'd0;
          state <= S_FIRST;
        end
        S_FIRST: begin
          if (n_cur == '0) begin
            chan_val <= dflt_val(ch);
            state    <= S_OUT;
          end else state <= S_LASTRD;
        end
        S_LASTRD: begin
          // first entry read data now valid
          r_lo <= rd_ratio;
          v_lo <= rd_val;
          if (ratio <= rd_ratio) begin
            chan_val <= rd_val;
            state    <= S_OUT;
          end else state <= S_LASTCHK;
        end
        S_LASTCHK: begin
          if (ratio >= rd_ratio) begin
            chan_val <= rd_val;
            state    <= S_OUT;
          end else begin
            idx   <= KeyIdxW'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: state <= S_SCANCHK;
        S_SCANCHK: begin
          if (ratio <= rd_ratio && rd_ratio > r_lo) begin
            r_hi  <= rd_ratio;
            v_hi  <= rd_val;
            state <= S_WDIV;
          end else begin
            r_lo  <= rd_ratio;
            v_lo  <= rd_val;
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_WDIV: begin
          div_start <= 1'b1;
          state     <= S_WWAIT;
        end
        S_WWAIT: if (div_done) begin
          t     <= div_q[16:0];
          state <= S_MUL;
        end
        S_MUL: begin
          for (int k = 0; k < 4; k++)
            prod[k] <= (34'(signed'(v_hi[16*k +: 16])) - 34'(signed'(v_lo[16*k +: 16])))
                       * signed'({17'd0, t});
          state <= S_ROUND;
        end
        S_ROUND: begin
          chan_val <= res;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid            <= 1'b1;
            out_data.out_channel <= ch;
            out_data.value_a     <= chan_val[15:0];
            out_data.value_b     <= chan_val[31:16];
            out_data.value_c     <= chan_val[47:32];
            out_data.value_d     <= (ch[0] == 1'b0) ? 16'sd0 : chan_val[63:48];
            out_data.is_paused   <= paused;
            out_data.last        <= (ch == 2'd3);
            ch    <= ch + 2'd1;
            state <= (ch == 2'd3) ? S_IDLE : S_FIRST;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_OUT)) out_valid <= 1'b0;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // Divider operands: ratio division or weight division
  always_comb begin
    if (state == S_RDIV || state == S_RWAIT) begin
      div_n = 33'({progress, 16'd0} - {16'd0, progress});
      div_d = dur;
    end else begin
      div_n = {1'b0, ratio - r_lo, 16'd0};
      div_d = {1'b0, r_hi - r_lo};
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = in_valid && in_ready && (in_data.func == FUNC_APPEND) &&
                (key_count[in_data.key_channel] < KeyCntW'(MaxKeys));
    mem_waddr = AddrW'({in_data.key_channel,
                        key_count[in_data.key_channel][KeyIdxW-1:0]});
    mem_wdata = {in_data.key_ratio, in_data.key_comp_d, in_data.key_comp_c,
                 in_data.key_comp_b, in_data.key_comp_a};
    unique case (state)
      S_FIRST:  mem_raddr = base;
      S_LASTRD: mem_raddr = base + AddrW'(n_cur - 1'b1);
      S_SCAN:   mem_raddr = base + AddrW'(idx);
      default:  mem_raddr = base;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    key_count[0] <= KeyCntW'(MaxKeys)) else $error("key count overflow");
  a_prog_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RWAIT) |-> (progress <= dur)) else $error("progress above duration");
`endif
endmodule

### sv/kat_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module kat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/kat_div.sv
// Restoring divider: 33-bit dividend by 17-bit divisor, one quotient bit a cycle.
module kat_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [32:0] quotient
);
  logic [5:0]  cnt;
  logic [17:0] rem;
  logic [32:0] q;
  logic [16:0] dvs;
  logic        busy;
  logic [17:0] trial;

  assign trial = {rem[16:0], q[32]};

  // Shift in one dividend bit and subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
        rem  <= '0;
        q    <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          q   <= {q[31:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy) else $error("divider woke by itself");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");
`endif
endmodule

### tb/sv/testbench.sv
// Testbench for the keyframe animation timeline: directed and random items against a predictor.
module testbench;
  import kat_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  keyframe_animation_timeline_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Timeline predictor and queue of pending track values
  class timeline_scoreboard;
    int unsigned dur_reg;
    int unsigned delay_reg;
    bit          loop_reg;
    int unsigned progress;
    int unsigned delay_left;
    bit          paused;
    int unsigned key_cnt [NumChan];
    logic [15:0] key_pos [NumChan][MaxKeys];
    logic [63:0] key_val [NumChan][MaxKeys];
    out_item_t   pending_values[$];
    int          errors;
    int          ticks;
    int          appends;
    int          results;

    function new();
      dur_reg = 1000;
      delay_reg = 0;
      loop_reg = 1;
      progress = 0;
      delay_left = 0;
      paused = 0;
      foreach (key_cnt[c]) key_cnt[c] = 0;
      errors = 0;
      ticks = 0;
      appends = 0;
      results = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == REG_DURATION) dur_reg = val;
      else if (idx == REG_START_DELAY) delay_reg = val;
      else if (idx == REG_LOOP_ENABLE) loop_reg = val[0];
    endfunction

    // Blend two Q8.8 components by weight, rounding half up with floor
    function logic signed [15:0] blend(logic signed [15:0] a, logic signed [15:0] b,
                                       longint unsigned w);
      longint p;
      longint q;
      p = (longint'(b) - longint'(a)) * longint'(w) + 32768;
      q = p >>> 16;
      return 16'(longint'(a) + q);
    endfunction

    function logic [63:0] track_value(int c, longint unsigned r);
      int unsigned n;
      logic [63:0] v;
      longint unsigned w;
      longint unsigned r1;
      longint unsigned r2;
      n = key_cnt[c];
      v = dflt_val(2'(c));
      if (n != 0) begin
        v = key_val[c][0];
        if (r > key_pos[c][0]) begin
          if (r >= key_pos[c][n-1]) begin
            v = key_val[c][n-1];
          end else begin
            for (int i = 0; i + 1 < n; i++) begin
              r1 = key_pos[c][i];
              r2 = key_pos[c][i+1];
              if (r <= r2 && r2 > r1) begin
                w = ((r - r1) << 16) / (r2 - r1);
                for (int k = 0; k < 4; k++)
                  v[16*k +: 16] = blend(key_val[c][i][16*k +: 16],
                                        key_val[c][i+1][16*k +: 16], w);
                break;
              end
            end
          end
        end
      end
      if (c == 0 || c == 2) v[63:48] = '0;
      return v;
    endfunction

    // Note an accepted input transfer and queue the track values it causes
    function void note_input(in_item_t it);
      int unsigned d;
      longint unsigned r;
      logic [63:0] v;
      out_item_t o;
      d = (dur_reg == 0) ? 1 : dur_reg;
      case (it.func)
        FUNC_APPEND: begin
          appends++;
          if (key_cnt[it.key_channel] < MaxKeys) begin
            key_pos[it.key_channel][key_cnt[it.key_channel]] = it.key_ratio;
            key_val[it.key_channel][key_cnt[it.key_channel]] =
              {it.key_comp_d, it.key_comp_c, it.key_comp_b, it.key_comp_a};
            key_cnt[it.key_channel]++;
          end
        end
        FUNC_PAUSE: paused = 1;
        FUNC_PLAY:  paused = 0;
        FUNC_INIT: begin
          progress = 0;
          delay_left = delay_reg;
        end
        FUNC_TICK: begin
          ticks++;
          if (!paused) begin
            if (delay_left > 0) begin
              delay_left = (delay_left > it.delta_time) ? delay_left - it.delta_time : 0;
            end else begin
              progress += it.delta_time;
              if (progress > d) begin
                if (loop_reg) progress = ((progress - 1) % d) + 1;
                else begin
                  progress = d;
                  paused = 1;
                end
              end
            end
          end
          r = (longint'(progress) * 65535) / d;
          if (r > 65535) r = 65535;
          for (int c = 0; c < NumChan; c++) begin
            v = track_value(c, r);
            o.out_channel = 2'(c);
            o.value_a = v[15:0];
            o.value_b = v[31:16];
            o.value_c = v[47:32];
            o.value_d = v[63:48];
            o.is_paused = paused;
            o.last = (c == NumChan - 1);
            pending_values.push_back(o);
          end
        end
        default: ;
      endcase
    endfunction

    // Check a result transfer against the oldest pending value
    task check_result(out_item_t got);
      out_item_t want;
      results++;
      if (pending_values.size() == 0) begin
        report("unexpected result", got, got);
        return;
      end
      want = pending_values.pop_front();
      if (got.out_channel != want.out_channel) report("out_channel", got, want);
      if (got.value_a != want.value_a) report("value_a", got, want);
      if (got.value_b != want.value_b) report("value_b", got, want);
      if (got.value_c != want.value_c) report("value_c", got, want);
      if (got.value_d != want.value_d) report("value_d", got, want);
      if (got.is_paused != want.is_paused) report("is_paused", got, want);
      if (got.last != want.last) report("last", got, want);
    endtask

    task report(string what, out_item_t got, out_item_t want);
      errors++;
      if (errors <= 40)
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask
  endclass

  timeline_scoreboard sb;
  int send_idle;
  int recv_stall;
  bit hold_off;
  int quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Monitor transfers on both channels and count quiet cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stall at random, or hold off entirely
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // Watchdog
  initial begin
    wait (quiet_cycles >= 20000);
    $display("watchdog expired at %0t", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one item; valid stays high after the transfer until the next call or drain
  task automatic send(in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [2:0] f);
    in_item_t it;
    it = '0;
    it.func = f;
    it.delta_time = 16'($urandom);
    it.key_channel = 2'($urandom);
    it.key_ratio = 16'($urandom);
    it.key_comp_a = 16'($urandom);
    it.key_comp_b = 16'($urandom);
    it.key_comp_c = 16'($urandom);
    it.key_comp_d = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t tick(logic [15:0] dt);
    in_item_t it;
    it = make_item(FUNC_TICK);
    it.delta_time = dt;
    return it;
  endfunction

  function automatic in_item_t key_item(logic [1:0] c, logic [15:0] r);
    in_item_t it;
    it = make_item(FUNC_APPEND);
    it.key_channel = c;
    it.key_ratio = r;
    return it;
  endfunction

  // Random timeline: mostly ascending keys, mostly small ticks, some control items
  task automatic random_phase(int count, int max_dt);
    int roll;
    in_item_t it;
    logic [15:0] next_pos [NumChan];
    foreach (next_pos[c]) next_pos[c] = 16'($urandom_range(2000));
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 55) it = tick(16'($urandom_range(max_dt)));
      else if (roll < 58) it = tick(16'($urandom));
      else if (roll < 80) begin
        it = key_item(2'($urandom), 16'd0);
        if ($urandom_range(9) == 0) it.key_ratio = 16'($urandom);
        else begin
          it.key_ratio = next_pos[it.key_channel];
          next_pos[it.key_channel] += 16'($urandom_range(9000));
        end
      end
      else if (roll < 85) it = make_item(FUNC_PAUSE);
      else if (roll < 91) it = make_item(FUNC_PLAY);
      else if (roll < 96) it = make_item(FUNC_INIT);
      else it = make_item(3'($urandom_range(7)));
      send(it);
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = REG_DURATION;
    cfg_wdata = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty tracks, extremes of fields, tick, append, pause, play and undefined codes
    send(tick(0));
    send(tick(16'hFFFF));
    send(key_item(0, 0));
    send(key_item(0, 16'hFFFF));
    begin
      in_item_t it;
      it = key_item(1, 100);
      it.key_comp_a = 16'sh8000; it.key_comp_b = 16'sh7FFF;
      it.key_comp_c = 16'sh8000; it.key_comp_d = 16'sh7FFF;
      send(it);
      it = key_item(1, 60000);
      it.key_comp_a = 16'sh7FFF; it.key_comp_b = 16'sh8000;
      it.key_comp_c = 16'sh7FFF; it.key_comp_d = 16'sh8000;
      send(it);
    end
    // unsorted keys on the scale track
    send(key_item(2, 40000));
    send(key_item(2, 10000));
    send(key_item(2, 30000));
    send(tick(300));
    send(make_item(FUNC_PAUSE));
    send(tick(100));
    send(make_item(FUNC_PLAY));
    send(tick(900));
    send(make_item(3'd5));
    send(make_item(3'd7));
    drain();

    // Zero duration, delay and clamping without loop
    write_cfg(REG_DURATION, 0);
    write_cfg(REG_START_DELAY, 16'hFFFF);
    write_cfg(REG_LOOP_ENABLE, 0);
    send(make_item(FUNC_INIT));
    send(tick(16'hFFFF));
    send(tick(5));
    send(make_item(FUNC_PLAY));
    send(tick(3));
    drain();

    // Fill the color track past capacity
    for (int i = 0; i < MaxKeys + 2; i++) send(key_item(3, 16'(i * 3500)));
    drain();

    // Random phases across settings and idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 75; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 75; end
        3: begin send_idle = 26; recv_stall = 26; end
        4: begin send_idle = 0;  recv_stall = 0;  end
        default: begin send_idle = 26; recv_stall = 75; end
      endcase
      write_cfg(REG_DURATION, (ph == 4) ? 16'hFFFF : 16'($urandom_range(200, 5000)));
      write_cfg(REG_START_DELAY, (ph == 2) ? 16'd0 : 16'($urandom_range(800)));
      write_cfg(REG_LOOP_ENABLE, 16'(ph & 1));
      send(make_item(FUNC_INIT));
      send(make_item(FUNC_PLAY));
      if (ph == 1) begin
        // long receiver hold-off while items keep coming
        fork
          begin
            hold_off = 1;
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
          begin
            random_phase(20, 400);
            in_valid <= 0;
          end
        join
      end
      random_phase(62, 600);
      drain();
    end

    $display("covered %0d ticks, %0d key appends, %0d track values checked",
             sb.ticks, sb.appends, sb.results);
    $display("registers swept incl. zero and full duration, loop on and off");
    if (sb.errors == 0 && sb.pending_values.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
